// File: rtl/dls_pkg.sv
// Shared types and constants for the display list sequencer.
package dls_pkg;

  // Fixed frame geometry.
  localparam logic [8:0] TOP_LINES    = 9'd8;
  localparam logic [8:0] VBLANK_LINE  = 9'd248;
  localparam logic [8:0] NARROW_WIDTH = 9'd256;
  localparam logic [8:0] NORMAL_WIDTH = 9'd320;
  localparam logic [8:0] WIDE_WIDTH   = 9'd384;
  localparam logic [8:0] LINE_MAX     = 9'd511;

  // Configuration register indexes.
  localparam logic CFG_DMA_CONTROL = 1'b0;
  localparam logic CFG_LIST_START  = 1'b1;

  // DMA control bits and width select codes.
  localparam int unsigned DMA_LIST_EN_BIT = 5;
  localparam logic [1:0] WSEL_OFF    = 2'd0;
  localparam logic [1:0] WSEL_NARROW = 2'd1;
  localparam logic [1:0] WSEL_NORMAL = 2'd2;
  localparam logic [1:0] WSEL_WIDE   = 2'd3;

  // Instruction bits and mode codes.
  localparam int unsigned INS_IRQ_BIT = 7;
  localparam int unsigned INS_LMS_BIT = 6;
  localparam int unsigned INS_HS_BIT  = 4;
  localparam logic [3:0] MODE_BLANK     = 4'h0;
  localparam logic [3:0] MODE_JUMP      = 4'h1;
  localparam logic [3:0] MODE_CHAR_6    = 4'h6;
  localparam logic [3:0] MODE_CHAR_7    = 4'h7;
  localparam logic [3:0] MODE_BITMAP_8  = 4'h8;
  localparam logic [3:0] MODE_BITMAP_B  = 4'hB;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_BLANK  = 3'd1,
    ACT_JUMP   = 3'd2,
    ACT_CHAR   = 3'd3,
    ACT_BITMAP = 3'd4
  } dls_action_e;

  typedef struct packed {
    logic        frame_start;
    logic [7:0]  instruction_byte;
    logic [15:0] operand_word;
  } dls_in_t;

  typedef struct packed {
    dls_action_e action;
    logic [3:0]  display_mode;
    logic [8:0]  first_line;
    logic [8:0]  lines_produced;
    logic [15:0] screen_address;
    logic [7:0]  bytes_fetched;
    logic [8:0]  playfield_width;
    logic        interrupt_request;
    logic        horizontal_scroll;
    logic [15:0] next_list_address;
    logic        list_running;
  } dls_out_t;

endpackage

// File: rtl/display_list_sequencer.sv
// Display list sequencer: decodes one display list instruction per word.
//
// Each input word is either a frame start or one display list instruction
// byte with the 16-bit operand that follows it in memory. The block keeps
// the list pointer, the screen-data pointer, the next render line and the
// list active flag, and returns exactly one result word per input word:
// the action taken, the lines rendered, the screen data fetched, the
// playfield width and the list pointer that follows. Throughput is one word
// per cycle while out_stall_i does not hold the result register. An accepted
// word passes through the input register, then the decode and state update
// into the result register. The rate is set by the state update loop. A
// result waiting on out_stall_i does not block the input register from
// filling; the input stalls only when both hold a word.
// Configuration writes (dma_control, list_start_address) take effect at the
// next clock and should only be issued while the block is idle.
module display_list_sequencer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  dls_pkg::dls_in_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output dls_pkg::dls_out_t out_word_o
);
  import dls_pkg::*;

  // Configuration registers.
  logic [7:0]  dma_control_q;
  logic [15:0] list_start_q;

  // Sequencer state.
  logic [15:0] list_ptr_q, list_ptr_d;
  logic [15:0] screen_ptr_q, screen_ptr_d;
  logic [8:0]  render_line_q, render_line_d;
  logic        active_q, active_d;
  logic [8:0]  width_q, width_d;

  // Pipeline registers.
  logic     in_valid_q;
  dls_in_t  in_word_q;
  logic     out_valid_q;
  dls_out_t out_word_q, out_word_d;

  logic in_accept;
  logic advance;

  // The result register is free when empty or being taken this cycle.
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // Configuration write port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dma_control_q <= '0;
      list_start_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DMA_CONTROL: dma_control_q <= cfg_wdata_i[7:0];
        CFG_LIST_START:  list_start_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input register: fill when empty or when the stage below can take its word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (advance || !in_valid_q) begin
      in_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_word_q <= in_word_i;
    end
  end

  // Decode and state update for the word in the input register.
  logic        dma_en;
  logic [1:0]  wsel;
  logic        lms;
  logic [3:0]  mode;
  logic [8:0]  sel_width;
  logic [8:0]  lines;
  logic [9:0]  line_sum;
  logic [8:0]  line_sat;

  always_comb begin
    dma_en = dma_control_q[DMA_LIST_EN_BIT];
    wsel   = dma_control_q[1:0];
    lms    = in_word_q.instruction_byte[INS_LMS_BIT];
    mode   = in_word_q.instruction_byte[3:0];

    unique case (wsel)
      WSEL_NARROW: sel_width = NARROW_WIDTH;
      WSEL_NORMAL: sel_width = NORMAL_WIDTH;
      WSEL_WIDE:   sel_width = WIDE_WIDTH;
      default:     sel_width = '0;
    endcase

    // Hold all state unless a branch below changes it.
    list_ptr_d    = list_ptr_q;
    screen_ptr_d  = screen_ptr_q;
    render_line_d = render_line_q;
    active_d      = active_q;
    width_d       = width_q;
    lines         = '0;

    out_word_d                   = '0;
    out_word_d.action            = ACT_NONE;
    out_word_d.first_line        = render_line_q;
    out_word_d.screen_address    = screen_ptr_q;

    priority if (in_word_q.frame_start) begin
      render_line_d = TOP_LINES;
      active_d      = dma_en;
      if (dma_en) begin
        list_ptr_d   = list_start_q;
        screen_ptr_d = '0;
      end
      out_word_d.first_line     = TOP_LINES;
      out_word_d.screen_address = screen_ptr_d;
    end else if (!active_q) begin
      // List idle: report nothing.
    end else if (!dma_en) begin
      active_d = 1'b0;
    end else if (render_line_q >= VBLANK_LINE) begin
      // Frame finished: wait for the next frame start.
    end else if (wsel != WSEL_OFF) begin
      width_d = sel_width;
      out_word_d.display_mode      = mode;
      out_word_d.interrupt_request = in_word_q.instruction_byte[INS_IRQ_BIT];
      out_word_d.horizontal_scroll = in_word_q.instruction_byte[INS_HS_BIT];
      priority if (mode == MODE_BLANK) begin
        out_word_d.action = ACT_BLANK;
        lines      = {5'd0, 1'b0, in_word_q.instruction_byte[6:4]} + 9'd1;
        list_ptr_d = list_ptr_q + 16'd1;
      end else if (mode == MODE_JUMP) begin
        out_word_d.action = ACT_JUMP;
        list_ptr_d = in_word_q.operand_word;
        // Jump and wait: run out the frame to vertical blank.
        if (lms) begin
          lines = VBLANK_LINE - render_line_q;
        end
      end else begin
        if (mode < MODE_BITMAP_8) begin
          out_word_d.action = ACT_CHAR;
          lines = (mode == MODE_CHAR_7) ? 9'd16 : 9'd8;
          out_word_d.bytes_fetched =
            (mode == MODE_CHAR_6 || mode == MODE_CHAR_7) ?
            {3'd0, sel_width[8:4]} : {2'd0, sel_width[8:3]};
        end else begin
          out_word_d.action = ACT_BITMAP;
          priority if (mode == MODE_BITMAP_8) begin
            lines = 9'd8;
            out_word_d.bytes_fetched = {4'd0, sel_width[8:5]};
          end else if (mode == MODE_BITMAP_B) begin
            lines = 9'd2;
            out_word_d.bytes_fetched = {3'd0, sel_width[8:4]};
          end else begin
            lines = 9'd1;
            out_word_d.bytes_fetched = {2'd0, sel_width[8:3]};
          end
        end
        // Load memory scan: take the operand as the new screen pointer.
        out_word_d.screen_address = lms ? in_word_q.operand_word : screen_ptr_q;
        screen_ptr_d = out_word_d.screen_address
                     + {8'd0, out_word_d.bytes_fetched};
        list_ptr_d   = list_ptr_q + (lms ? 16'd3 : 16'd1);
      end
    end else begin
      // Width select off: hold everything and report nothing.
    end

    // Advance the render line, saturating at the last line.
    line_sum = {1'b0, render_line_q} + {1'b0, lines};
    line_sat = line_sum[9] ? LINE_MAX : line_sum[8:0];
    if (lines != '0) begin
      render_line_d = line_sat;
    end

    out_word_d.lines_produced    = lines;
    out_word_d.playfield_width   = width_d;
    out_word_d.next_list_address = list_ptr_d;
    out_word_d.list_running      = active_d;
  end

  // Commit state when the input word moves into the result register.
  logic fire;
  assign fire = in_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_ptr_q    <= '0;
      screen_ptr_q  <= '0;
      render_line_q <= '0;
      active_q      <= 1'b0;
      width_q       <= '0;
    end else if (fire) begin
      list_ptr_q    <= list_ptr_d;
      screen_ptr_q  <= screen_ptr_d;
      render_line_q <= render_line_d;
      active_q      <= active_d;
      width_q       <= width_d;
    end
  end

  // Result register: load on fire, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_word_q <= out_word_d;
    end
  end

endmodule

// File: rtl/dls_checker.sv
// Port-level checks for the display list sequencer, bound to its top level.
module dls_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input dls_pkg::dls_out_t out_word_o
);
  import dls_pkg::*;

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // The input only backs up when the result side is stalled.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  // No action means no lines, no data and no mode.
  a_none_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.action == ACT_NONE |->
      out_word_o.lines_produced == '0 && out_word_o.bytes_fetched == '0 &&
      out_word_o.display_mode == '0)
    else $error("idle result carries data");

  // Mode lines always fetch screen data at a nonzero width.
  a_mode_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.action == ACT_CHAR ||
                    out_word_o.action == ACT_BITMAP) |->
      out_word_o.bytes_fetched != '0 && out_word_o.playfield_width != '0 &&
      out_word_o.lines_produced != '0)
    else $error("mode line without fetch");

  // A stopped list reports no action.
  a_stopped_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.list_running |-> out_word_o.action == ACT_NONE)
    else $error("action reported with list stopped");

endmodule

bind display_list_sequencer dls_checker u_dls_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_word_o (out_word_o)
);
